// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TCCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcce checker: assertion failed");

// A signal holds its value in the cycle after a condition.
`define TCCE_ASSERT_HOLD(lbl, cond, sig) \
  `TCCE_ASSERT(lbl, (cond) |=> $stable(sig))

`endif

// ----- src/tcce_pkg.sv -----
`default_nettype none

package tcce_pkg;

  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;
  localparam int unsigned FIFO_DEPTH   = 4;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  COLOUR_RST = 8'd7;
  localparam logic [15:0] RESET_CELL = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic [7:0] cell_colour;
  } tcce_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic        scrolled;
    logic [15:0] cell_data;
    logic        bad_position;
  } tcce_out_t;

  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_NEWLINE,
    KIND_TAB,
    KIND_WRITE,
    KIND_READ,
    KIND_NOP
  } kind_e;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] colour;
    logic       bad;
  } tcce_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcce_q_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_SCROLL
  } back_state_e;

endpackage

`default_nettype wire

// ----- src/tcce_fifo.sv -----
`default_nettype none

module tcce_fifo import tcce_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcce_cmd_t      data_i,
  input  logic           pop_i,
  output tcce_cmd_t      data_o,
  output tcce_q_status_t status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  tcce_cmd_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == NW'(DEPTH));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/tcce_ram.sv -----
`default_nettype none

module tcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/tcce_front.sv -----
`default_nettype none

module tcce_front import tcce_pkg::*; #(
  parameter int unsigned ROWS    = ROWS_DEF,
  parameter int unsigned COLUMNS = COLUMNS_DEF
) (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcce_in_t       in_data_i,
  input  logic           init_done_i,
  input  tcce_q_status_t q_status_i,
  output logic           push_o,
  output tcce_cmd_t      cmd_o
);

  logic off_screen;

  // Beats are held off until the screen store has been cleared and while the command queue is full.
  assign in_ready_o = init_done_i && !q_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  assign off_screen = ({1'b0, in_data_i.cell_row} >= 6'(ROWS)) ||
                      ({1'b0, in_data_i.cell_col} >= 8'(COLUMNS));

  always_comb begin
    cmd_o.char_code = in_data_i.char_code;
    cmd_o.row       = in_data_i.cell_row;
    cmd_o.col       = in_data_i.cell_col;
    cmd_o.colour    = in_data_i.cell_colour;
    cmd_o.bad       = 1'b0;
    cmd_o.kind      = KIND_NOP;
    case (op_e'(in_data_i.operation))
      OP_PUT: begin
        if (in_data_i.char_code == CH_NEWLINE) begin
          cmd_o.kind = KIND_NEWLINE;
        end else if (in_data_i.char_code == CH_TAB) begin
          cmd_o.kind = KIND_TAB;
        end else begin
          cmd_o.kind = KIND_CHAR;
        end
      end
      OP_WRITE: begin
        cmd_o.bad  = off_screen;
        cmd_o.kind = off_screen ? KIND_NOP : KIND_WRITE;
      end
      OP_READ: begin
        cmd_o.bad  = off_screen;
        cmd_o.kind = off_screen ? KIND_NOP : KIND_READ;
      end
      default: begin
        cmd_o.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/tcce_back.sv -----
`default_nettype none

module tcce_back import tcce_pkg::*; #(
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [7:0]     cfg_data_i,
  input  tcce_q_status_t q_status_i,
  input  tcce_cmd_t      cmd_i,
  output logic           pop_o,
  output logic           init_done_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcce_out_t      out_data_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = $clog2(TAB_STOP + 1);
  localparam int unsigned TW    = $clog2(COLUMNS + TAB_STOP + 1);

  back_state_e   state_q, state_d;
  logic [7:0]    text_colour_q, text_colour_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [PW-1:0] phase_q, phase_d;
  logic [RW-1:0] top_q, top_d;
  logic [AW-1:0] init_cnt_q, init_cnt_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AW-1:0] clr_base_q, clr_base_d;
  tcce_out_t     res_q, res_d;
  tcce_out_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  // Logical row and column to a place in the row ring of the store.
  function automatic logic [AW-1:0] phys_addr(input logic [RW-1:0] top,
                                              input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    logic [RW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return AW'(sum[RW-1:0]) * AW'(COLUMNS) + AW'(col);
  endfunction

  assign init_done_o = (state_q != BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic          take_nl;
    logic          scroll;
    logic          out_free;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [TW-1:0] tab_col;
    tcce_out_t     res;

    state_d       = state_q;
    text_colour_d = cfg_valid_i ? cfg_data_i : text_colour_q;
    cur_row_d     = cur_row_q;
    cur_col_d     = cur_col_q;
    phase_d       = phase_q;
    top_d         = top_q;
    init_cnt_d    = init_cnt_q;
    clr_cnt_d     = clr_cnt_q;
    clr_base_d    = clr_base_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    pop_o         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = init_cnt_q;
    ram_wdata     = RESET_CELL;
    ram_re        = 1'b0;
    ram_raddr     = phys_addr(top_q, cmd_i.row[RW-1:0], cmd_i.col[CW-1:0]);
    take_nl       = 1'b0;
    scroll        = 1'b0;
    out_free      = !out_valid_q || out_ready_i;
    col_inc       = {1'b0, cur_col_q} + (CW+1)'(1);
    row_inc       = {1'b0, cur_row_q} + (RW+1)'(1);
    tab_col       = TW'(cur_col_q) - TW'(phase_q) + TW'(TAB_STOP);
    res           = '0;

    case (state_q)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt_q;
        ram_wdata = RESET_CELL;
        if (init_cnt_q == AW'(CELLS - 1)) begin
          state_d = BK_IDLE;
        end else begin
          init_cnt_d = init_cnt_q + AW'(1);
        end
      end
      BK_IDLE: begin
        // A command is taken only when the output register is free, so a
        // read or a scroll can finish later without waiting on the sink.
        if (!q_status_i.empty && out_free) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            KIND_CHAR: begin
              ram_we    = 1'b1;
              ram_waddr = phys_addr(top_q, cur_row_q, cur_col_q);
              ram_wdata = {text_colour_q, cmd_i.char_code};
              if (col_inc >= (CW+1)'(COLUMNS)) begin
                take_nl = 1'b1;
              end else begin
                cur_col_d = col_inc[CW-1:0];
                phase_d   = (phase_q == PW'(TAB_STOP - 1)) ? '0 : phase_q + PW'(1);
              end
            end
            KIND_NEWLINE: begin
              take_nl = 1'b1;
            end
            KIND_TAB: begin
              if (tab_col >= TW'(COLUMNS)) begin
                take_nl = 1'b1;
              end else begin
                cur_col_d = tab_col[CW-1:0];
                phase_d   = '0;
              end
            end
            KIND_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = phys_addr(top_q, cmd_i.row[RW-1:0], cmd_i.col[CW-1:0]);
              ram_wdata = {cmd_i.colour, cmd_i.char_code};
            end
            KIND_READ: begin
              ram_re  = 1'b1;
              state_d = BK_READ;
            end
            default: begin
            end
          endcase

          if (take_nl) begin
            cur_col_d = '0;
            phase_d   = '0;
            if (row_inc >= (RW+1)'(ROWS)) begin
              // The old top row becomes the new bottom row and is blanked.
              scroll     = 1'b1;
              cur_row_d  = RW'(ROWS - 1);
              top_d      = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
              clr_base_d = AW'(top_q) * AW'(COLUMNS);
              clr_cnt_d  = '0;
              state_d    = BK_SCROLL;
            end else begin
              cur_row_d = row_inc[RW-1:0];
            end
          end

          res.cursor_row_out = 5'(cur_row_d);
          res.cursor_col_out = 7'(cur_col_d);
          res.scrolled       = scroll;
          res.cell_data      = '0;
          res.bad_position   = cmd_i.bad;

          if (cmd_i.kind == KIND_READ || scroll) begin
            res_d = res;
          end else begin
            out_d       = res;
            out_valid_d = 1'b1;
          end
        end
      end
      BK_READ: begin
        out_d           = res_q;
        out_d.cell_data = ram_rdata;
        out_valid_d     = 1'b1;
        state_d         = BK_IDLE;
      end
      BK_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = clr_base_q + AW'(clr_cnt_q);
        ram_wdata = {text_colour_q, CH_SPACE};
        if (clr_cnt_q == CW'(COLUMNS - 1)) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BK_CLEAR;
      text_colour_q <= COLOUR_RST;
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      phase_q       <= '0;
      top_q         <= '0;
      init_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      text_colour_q <= text_colour_d;
      cur_row_q     <= cur_row_d;
      cur_col_q     <= cur_col_d;
      phase_q       <= phase_d;
      top_q         <= top_d;
      init_cnt_q    <= init_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_cnt_q  <= clr_cnt_d;
    clr_base_q <= clr_base_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ----- src/text_console_cursor_engine.sv -----
// Text console engine: a ROWS x COLUMNS screen of 16-bit cells (attribute in
// the high byte, character in the low byte), a cursor and a ring of rows that
// scrolls. After reset the block fills the screen with grey spaces and holds
// in_ready_o low meanwhile; the colour register is writable at any time. A
// front end classifies each input beat into a short command queue and a back
// end executes it against a screen RAM with one write and one read port. A
// character, newline, tab or cell write is done in the idle state, a cell read
// goes on through the read state (the RAM read is registered), and a command
// that scrolls goes on through the scroll state, which blanks the new bottom
// row one cell per cycle. A result leaves through an output register, so the
// next command runs once that register has been taken.
`default_nettype none

module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tcce_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tcce_out_t out_data_o
);

  tcce_q_status_t q_status;
  tcce_cmd_t      push_cmd, pop_cmd;
  logic           push, pop, init_done;

  assign cfg_ready_o = 1'b1;

  tcce_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .init_done_i (init_done),
    .q_status_i  (q_status),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tcce_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (pop),
    .data_o   (pop_cmd),
    .status_o (q_status)
  );

  tcce_back #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- src/tcce_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module tcce_checker import tcce_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input tcce_out_t out_data_o
);

  // A stalled result beat stays offered and unchanged.
  `TCCE_ASSERT(out_valid_held, out_valid_o && !out_ready_i |=> out_valid_o)
  `TCCE_ASSERT_HOLD(out_data_held, out_valid_o && !out_ready_i, out_data_o)

  // The screen is still being cleared right after reset.
  `TCCE_ASSERT(no_accept_after_reset, $rose(rst_ni) |-> !in_ready_o)

  // A scroll always leaves the cursor at the start of the bottom row.
  `TCCE_ASSERT(scroll_cursor_home, out_valid_o && out_data_o.scrolled |->
      out_data_o.cursor_row_out == 5'(ROWS - 1) && out_data_o.cursor_col_out == 7'd0)

endmodule

bind text_console_cursor_engine tcce_checker #(
  .ROWS (ROWS)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- test/tcce_screen_checker.sv -----
`timescale 1ns / 1ps

module tcce_screen_checker import tcce_pkg::*; #(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  tcce_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  tcce_out_t out_data_i,
  output int        errors_o,
  output int        pending_o
);

  logic [15:0] screen_cells [ROWS*COLUMNS];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned top_row;
  logic [7:0]  text_attr;
  tcce_out_t   expected_q [$];
  tcce_out_t   predicted;
  tcce_out_t   oldest;
  int          fail_count;

  // Screen rows are logical; the ring offset maps them onto the store.
  function automatic int unsigned cell_addr(int unsigned row, int unsigned col);
    return ((top_row + row) % ROWS) * COLUMNS + col;
  endfunction

  task automatic next_line(output logic scrolled);
    scrolled = 1'b0;
    cur_row++;
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      top_row = (top_row + 1) % ROWS;
      for (int c = 0; c < COLUMNS; c++) begin
        screen_cells[cell_addr(cur_row, c)] = {text_attr, CH_SPACE};
      end
      scrolled = 1'b1;
    end
    cur_col = 0;
  endtask

  task automatic predict_console(input tcce_in_t beat, output tcce_out_t res);
    logic        scr;
    logic        bad;
    logic [15:0] data;
    int unsigned r;
    int unsigned c;
    scr  = 1'b0;
    bad  = 1'b0;
    data = '0;
    r    = beat.cell_row;
    c    = beat.cell_col;
    case (op_e'(beat.operation))
      OP_PUT: begin
        if (beat.char_code == CH_NEWLINE) begin
          next_line(scr);
        end else if (beat.char_code == CH_TAB) begin
          cur_col = cur_col - cur_col % TAB_STOP + TAB_STOP;
          if (cur_col >= COLUMNS) next_line(scr);
        end else begin
          screen_cells[cell_addr(cur_row, cur_col)] = {text_attr, beat.char_code};
          cur_col++;
          if (cur_col >= COLUMNS) next_line(scr);
        end
      end
      OP_WRITE, OP_READ: begin
        if (r >= ROWS || c >= COLUMNS) begin
          bad = 1'b1;
        end else if (op_e'(beat.operation) == OP_WRITE) begin
          screen_cells[cell_addr(r, c)] = {beat.cell_colour, beat.char_code};
        end else begin
          data = screen_cells[cell_addr(r, c)];
        end
      end
      default: ;
    endcase
    res.cursor_row_out = 5'(cur_row);
    res.cursor_col_out = 7'(cur_col);
    res.scrolled       = scr;
    res.cell_data      = data;
    res.bad_position   = bad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS * COLUMNS; i++) screen_cells[i] = RESET_CELL;
      cur_row    = 0;
      cur_col    = 0;
      top_row    = 0;
      text_attr  = COLOUR_RST;
      fail_count = 0;
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) text_attr = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        predict_console(in_data_i, predicted);
        expected_q.push_back(predicted);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%t: result beat with nothing expected: row %0d col %0d scr %0b data %h bad %0b",
                     $realtime, out_data_i.cursor_row_out, out_data_i.cursor_col_out,
                     out_data_i.scrolled, out_data_i.cell_data, out_data_i.bad_position);
          end
        end else begin
          oldest = expected_q.pop_front();
          if (out_data_i.cursor_row_out !== oldest.cursor_row_out ||
              out_data_i.cursor_col_out !== oldest.cursor_col_out ||
              out_data_i.scrolled       !== oldest.scrolled       ||
              out_data_i.cell_data      !== oldest.cell_data      ||
              out_data_i.bad_position   !== oldest.bad_position) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%t: mismatch: expected row %0d col %0d scr %0b data %h bad %0b",
                       $realtime, oldest.cursor_row_out, oldest.cursor_col_out,
                       oldest.scrolled, oldest.cell_data, oldest.bad_position);
              $display("%t:           got      row %0d col %0d scr %0b data %h bad %0b",
                       $realtime, out_data_i.cursor_row_out, out_data_i.cursor_col_out,
                       out_data_i.scrolled, out_data_i.cell_data, out_data_i.bad_position);
            end
          end
        end
      end
      errors_o  <= fail_count;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- test/tb_text_console_cursor_engine.sv -----
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  localparam int unsigned COLUMNS = COLUMNS_DEF;
  localparam int unsigned ROWS    = ROWS_DEF;
  // Longer than the slowest command, a scroll that blanks a whole row.
  localparam int unsigned SETTLE_CYCLES = 2 * COLUMNS + 20;
  localparam int unsigned PHASE_BEATS   = 315;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BLOCKY} rx_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  tcce_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  tcce_out_t out_data_o;
  int        mismatch_count;
  int        pending_count;
  int        burst_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  text_console_cursor_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  tcce_screen_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .errors_o    (mismatch_count),
    .pending_o   (pending_count)
  );

  initial begin : watchdog
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver switches between stall patterns over stretches of random length.
  initial begin : rx_pattern
    int       stretch;
    rx_mode_e mode;
    out_ready_i = 1'b0;
    stretch     = 0;
    mode        = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(10, 150);
      end
      stretch--;
      case (mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= ($urandom_range(0, 15) == 0) ? ~out_ready_i : out_ready_i;
      endcase
    end
  end

  function automatic tcce_in_t make_beat(op_e op, logic [7:0] ch, logic [4:0] row,
                                         logic [6:0] col, logic [7:0] colour);
    tcce_in_t b;
    b.operation   = op;
    b.char_code   = ch;
    b.cell_row    = row;
    b.cell_col    = col;
    b.cell_colour = colour;
    return b;
  endfunction

  function automatic tcce_in_t random_beat();
    tcce_in_t    b;
    int unsigned pick;
    b.char_code   = 8'($urandom);
    b.cell_row    = 5'($urandom);
    b.cell_col    = 7'($urandom);
    b.cell_colour = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      b.operation = OP_PUT;
      case ($urandom_range(0, 9))
        0:       b.char_code = CH_NEWLINE;
        1:       b.char_code = CH_TAB;
        default: ;
      endcase
    end else if (pick < 75) begin
      b.operation = OP_WRITE;
    end else if (pick < 95) begin
      b.operation = OP_READ;
    end else begin
      b.operation = OP_NONE;
    end
    // Cell accesses mostly land on the screen; the rest use the full field range.
    if ((b.operation == OP_WRITE || b.operation == OP_READ) && $urandom_range(0, 9) != 0) begin
      b.cell_row = 5'($urandom_range(0, ROWS - 1));
      b.cell_col = 7'($urandom_range(0, COLUMNS - 1));
    end
    return b;
  endfunction

  task automatic send_beat(input tcce_in_t beat);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
      gap        = $urandom_range(0, 9) == 0 ? $urandom_range(6, 20) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_colour(input logic [7:0] attr);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= attr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every expected result, then let any trailing work finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] colour_plan [6];
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    burst_left  = 0;
    colour_plan = '{8'h00, 8'hFF, 8'h1E, 8'($urandom), 8'h70, COLOUR_RST};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the colour still at its reset value.
    send_beat(make_beat(OP_READ, 8'h00, 5'd0, 7'd0, 8'h00));
    send_beat(make_beat(OP_READ, 8'hFF, 5'd24, 7'd79, 8'hFF));
    send_beat(make_beat(OP_PUT, 8'h41, 5'd31, 7'd127, 8'hFF));
    send_beat(make_beat(OP_PUT, 8'h00, 5'd0, 7'd0, 8'h00));
    send_beat(make_beat(OP_PUT, 8'hFF, 5'd0, 7'd0, 8'h00));
    send_beat(make_beat(OP_PUT, CH_TAB, 5'd0, 7'd0, 8'h00));
    send_beat(make_beat(OP_PUT, CH_NEWLINE, 5'd31, 7'd127, 8'hFF));
    send_beat(make_beat(OP_WRITE, 8'hFF, 5'd0, 7'd0, 8'hFF));
    send_beat(make_beat(OP_READ, 8'h00, 5'd0, 7'd0, 8'h00));
    send_beat(make_beat(OP_WRITE, 8'h00, 5'd24, 7'd79, 8'h00));
    send_beat(make_beat(OP_READ, 8'h00, 5'd24, 7'd79, 8'h00));
    // Off-screen accesses are flagged and leave the store alone.
    send_beat(make_beat(OP_WRITE, 8'h55, 5'd25, 7'd0, 8'hAA));
    send_beat(make_beat(OP_READ, 8'h00, 5'd0, 7'd80, 8'h00));
    send_beat(make_beat(OP_READ, 8'hFF, 5'd31, 7'd127, 8'hFF));
    send_beat(make_beat(OP_WRITE, 8'h55, 5'd24, 7'd127, 8'hAA));
    send_beat(make_beat(OP_NONE, 8'hFF, 5'd31, 7'd127, 8'hFF));
    // Tabs across the line until one runs past the right edge.
    repeat (10) send_beat(make_beat(OP_PUT, CH_TAB, 5'd0, 7'd0, 8'h00));
    settle();

    foreach (colour_plan[p]) begin
      write_colour(colour_plan[p]);
      repeat (PHASE_BEATS) send_beat(random_beat());
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/tcce_pkg.sv
src/tcce_fifo.sv
src/tcce_ram.sv
src/tcce_front.sv
src/tcce_back.sv
src/text_console_cursor_engine.sv
src/tcce_checker.sv
test/tcce_screen_checker.sv
test/tb_text_console_cursor_engine.sv
